// ----- rtl/ptr_pkg.sv -----
// ----------------------------------------------------------------------------
// ptr_pkg
// Shared types, codes and helpers of the planar tile pixel renderer.
// ----------------------------------------------------------------------------
package ptr_pkg;

   localparam int VIDEO_WORDS_DEF = 32768;
   localparam int COLOUR_ENTRIES  = 256;
   localparam int COLOUR_AW       = 8;

   // request actions
   localparam logic [1:0] ACT_VID_WR = 2'd0;
   localparam logic [1:0] ACT_COL_WR = 2'd1;
   localparam logic [1:0] ACT_RENDER = 2'd2;

   // register indexes
   localparam logic [1:0] REG_COLOR_DEPTH = 2'd0;
   localparam logic [1:0] REG_BIG_TILES   = 2'd1;
   localparam logic [1:0] REG_HIRES       = 2'd2;
   localparam logic [1:0] REG_TILE_BASE   = 2'd3;

   // colour depth codes
   localparam logic [1:0] DEPTH_2BPP   = 2'd0;
   localparam logic [1:0] DEPTH_4BPP   = 2'd1;
   localparam logic [1:0] DEPTH_8BPP   = 2'd2;
   localparam logic [1:0] DEPTH_AFFINE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PL_FETCH,
      ST_PL_WAIT,
      ST_PL_PIXEL,
      ST_MAP_RD,
      ST_MAP_LATCH,
      ST_AF_FETCH,
      ST_AF_PIXEL
   } state_type;

   typedef enum logic [1:0] {
      VSRC_MAP,
      VSRC_PLANE,
      VSRC_AFFINE
   } vid_src_type;

   typedef struct packed {
      logic [1:0]  color_depth;
      logic        big_tiles;
      logic        hires;
      logic [14:0] tile_data_base;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic        vid_wr;
      logic        col_wr;
      logic        vid_rd;
      vid_src_type vid_src;
      logic        chr_latch;
      logic        pix_issue;
      logic        pix_last;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [1:0]  plane;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

endpackage

// ----- rtl/ptr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptr_ctrl
// Sequencer: accepts requests, steps rows, columns and plane fetches.
// ----------------------------------------------------------------------------
module ptr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   input  logic [1:0]            cfg_depth,
   input  ptr_pkg::status_type   status,
   output logic                  req_ready,
   output ptr_pkg::cmd_type      cmd
);

   ptr_pkg::state_type state_ff, state_in;
   logic [2:0] row_ff, row_in;
   logic [2:0] col_ff, col_in;
   logic [1:0] plane_ff, plane_in;
   logic [1:0] last_plane;
   logic       accept;
   logic       final_pix;

   assign req_ready = (state_ff == ptr_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign final_pix = (row_ff == 3'd7) && (col_ff == 3'd7);

   always_comb begin
      unique case (cfg_depth)
         ptr_pkg::DEPTH_2BPP: last_plane = 2'd0;
         ptr_pkg::DEPTH_4BPP: last_plane = 2'd1;
         default:             last_plane = 2'd3;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptr_pkg::ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         plane_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         plane_ff <= plane_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptr_pkg::ST_IDLE: begin
            if (accept && req_action == ptr_pkg::ACT_RENDER) begin
               state_in = (cfg_depth == ptr_pkg::DEPTH_AFFINE) ? ptr_pkg::ST_MAP_RD
                                                               : ptr_pkg::ST_PL_FETCH;
            end
         end
         ptr_pkg::ST_PL_FETCH: begin
            if (plane_ff == last_plane) state_in = ptr_pkg::ST_PL_WAIT;
         end
         ptr_pkg::ST_PL_WAIT:   state_in = ptr_pkg::ST_PL_PIXEL;
         ptr_pkg::ST_PL_PIXEL: begin
            if (status.out_free && col_ff == 3'd7) begin
               state_in = (row_ff == 3'd7) ? ptr_pkg::ST_IDLE : ptr_pkg::ST_PL_FETCH;
            end
         end
         ptr_pkg::ST_MAP_RD:    state_in = ptr_pkg::ST_MAP_LATCH;
         ptr_pkg::ST_MAP_LATCH: state_in = ptr_pkg::ST_AF_FETCH;
         ptr_pkg::ST_AF_FETCH:  state_in = ptr_pkg::ST_AF_PIXEL;
         ptr_pkg::ST_AF_PIXEL: begin
            if (status.out_free) begin
               state_in = final_pix ? ptr_pkg::ST_IDLE : ptr_pkg::ST_AF_FETCH;
            end
         end
         default:               state_in = ptr_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd          = '0;
      cmd.vid_src  = ptr_pkg::VSRC_MAP;
      cmd.row      = row_ff;
      cmd.col      = col_ff;
      cmd.plane    = plane_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      plane_in     = plane_ff;
      unique case (state_ff)
         ptr_pkg::ST_IDLE: begin
            cmd.vid_wr = accept && (req_action == ptr_pkg::ACT_VID_WR);
            cmd.col_wr = accept && (req_action == ptr_pkg::ACT_COL_WR);
            cmd.load   = accept && (req_action == ptr_pkg::ACT_RENDER);
            row_in     = '0;
            col_in     = '0;
            plane_in   = '0;
         end
         ptr_pkg::ST_PL_FETCH: begin
            cmd.vid_rd  = 1'b1;
            cmd.vid_src = ptr_pkg::VSRC_PLANE;
            plane_in    = (plane_ff == last_plane) ? 2'd0 : plane_ff + 2'd1;
         end
         ptr_pkg::ST_PL_PIXEL, ptr_pkg::ST_AF_PIXEL: begin
            if (status.out_free) begin
               cmd.pix_issue = 1'b1;
               cmd.pix_last  = final_pix;
               col_in        = col_ff + 3'd1;
               if (col_ff == 3'd7) row_in = row_ff + 3'd1;
            end
         end
         ptr_pkg::ST_MAP_RD: begin
            cmd.vid_rd  = 1'b1;
            cmd.vid_src = ptr_pkg::VSRC_MAP;
         end
         ptr_pkg::ST_MAP_LATCH: cmd.chr_latch = 1'b1;
         ptr_pkg::ST_AF_FETCH: begin
            cmd.vid_rd  = 1'b1;
            cmd.vid_src = ptr_pkg::VSRC_AFFINE;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/ptr_datapath.sv -----
// ----------------------------------------------------------------------------
// ptr_datapath
// Video word memory, colour table, bitplane gather and result register.
// ----------------------------------------------------------------------------
module ptr_datapath #(
   parameter int VIDEO_WORDS = ptr_pkg::VIDEO_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ptr_pkg::cfg_type     cfg,
   input  ptr_pkg::cmd_type     cmd,
   input  logic [14:0]          req_address,
   input  logic [15:0]          req_data,
   input  logic [15:0]          req_map_entry,
   input  logic [6:0]           req_tile_x,
   input  logic [6:0]           req_tile_y,
   input  logic                 rsp_ready,
   output ptr_pkg::status_type  status,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_pixel_col,
   output logic [2:0]           rsp_pixel_row,
   output logic [7:0]           rsp_color_index,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue,
   output logic                 rsp_last
);

   localparam int AW = $clog2(VIDEO_WORDS);

   logic [15:0] vid_mem [VIDEO_WORDS];
   logic [14:0] col_mem [ptr_pkg::COLOUR_ENTRIES];

   logic [AW-1:0] base_ff, base_in;
   logic          mx_ff, my_ff;
   logic [2:0]    pal_ff;
   logic [6:0]    tx_ff, ty_ff;
   logic [7:0]    chr_ff;
   logic [15:0]   vid_q_ff;
   logic          lat_en_ff;
   logic [1:0]    lat_idx_ff;
   logic [15:0]   plane_ff [4];
   logic          rsp_valid_ff;
   logic [2:0]    out_col_ff, out_row_ff;
   logic [7:0]    out_idx_ff;
   logic          out_last_ff;
   logic [14:0]   colour_ff;

   logic          mx, my, wide;
   logic [9:0]    chr_adj;
   logic [14:0]   chr_scaled;
   logic [16:0]   base_sum;
   logic [2:0]    src_row;
   logic [2:0]    bit_sel;
   logic [AW-1:0] vid_addr, mem_addr;
   logic [7:0]    raw_idx, masked_idx, pal_offset, pix_idx;

   // character base on load
   assign mx   = req_map_entry[14];
   assign my   = req_map_entry[15];
   assign wide = cfg.big_tiles | cfg.hires;
   assign chr_adj = req_map_entry[9:0]
                  + {5'b0, cfg.big_tiles & (req_tile_y[0] ^ my), 3'b0,
                     wide & (req_tile_x[0] ^ mx)};

   always_comb begin
      unique case (cfg.color_depth)
         ptr_pkg::DEPTH_2BPP: chr_scaled = {2'b0, chr_adj, 3'b0};
         ptr_pkg::DEPTH_4BPP: chr_scaled = {1'b0, chr_adj, 4'b0};
         default:             chr_scaled = {chr_adj, 5'b0};
      endcase
   end

   assign base_sum = {2'b0, cfg.tile_data_base} + {2'b0, chr_scaled};
   assign base_in  = base_sum[AW-1:0];

   // video address
   assign src_row = my_ff ? ~cmd.row : cmd.row;

   always_comb begin
      unique case (cmd.vid_src)
         ptr_pkg::VSRC_MAP:    vid_addr = AW'({ty_ff, tx_ff});
         ptr_pkg::VSRC_PLANE:  vid_addr = base_ff + AW'({cmd.plane, src_row});
         ptr_pkg::VSRC_AFFINE: vid_addr = AW'({chr_ff, cmd.row, cmd.col});
         default:              vid_addr = '0;
      endcase
   end

   assign mem_addr = cmd.vid_wr ? AW'({1'b0, req_address}) : vid_addr;

   always_ff @(posedge clock) begin
      if (cmd.vid_wr) vid_mem[mem_addr] <= req_data;
      if (cmd.vid_rd) vid_q_ff <= vid_mem[mem_addr];
   end

   // pixel index
   assign bit_sel = mx_ff ? cmd.col : ~cmd.col;

   always_comb begin
      for (int p = 0; p < 4; p++) begin
         raw_idx[2*p]   = plane_ff[p][{1'b0, bit_sel}];
         raw_idx[2*p+1] = plane_ff[p][{1'b1, bit_sel}];
      end
   end

   always_comb begin
      unique case (cfg.color_depth)
         ptr_pkg::DEPTH_2BPP: begin
            masked_idx = raw_idx & 8'h03;
            pal_offset = {3'b0, pal_ff, 2'b0};
         end
         ptr_pkg::DEPTH_4BPP: begin
            masked_idx = raw_idx & 8'h0f;
            pal_offset = {1'b0, pal_ff, 4'b0};
         end
         default: begin
            masked_idx = raw_idx;
            pal_offset = '0;
         end
      endcase
   end

   assign pix_idx = (cfg.color_depth == ptr_pkg::DEPTH_AFFINE) ? vid_q_ff[15:8]
                                                               : masked_idx + pal_offset;

   always_ff @(posedge clock) begin
      if (cmd.col_wr) col_mem[req_address[ptr_pkg::COLOUR_AW-1:0]] <= req_data[14:0];
      if (cmd.pix_issue) colour_ff <= col_mem[pix_idx];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= base_in;
         mx_ff   <= mx;
         my_ff   <= my;
         pal_ff  <= req_map_entry[12:10];
         tx_ff   <= req_tile_x;
         ty_ff   <= req_tile_y;
      end
      if (cmd.chr_latch) chr_ff <= vid_q_ff[7:0];
      lat_idx_ff <= cmd.plane;
      if (lat_en_ff) plane_ff[lat_idx_ff] <= vid_q_ff;
      if (cmd.pix_issue) begin
         out_col_ff  <= cmd.col;
         out_row_ff  <= cmd.row;
         out_idx_ff  <= pix_idx;
         out_last_ff <= cmd.pix_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lat_en_ff <= cmd.vid_rd && (cmd.vid_src == ptr_pkg::VSRC_PLANE);
         if (cmd.pix_issue) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_col   = out_col_ff;
   assign rsp_pixel_row   = out_row_ff;
   assign rsp_color_index = out_idx_ff;
   assign rsp_red         = ptr_pkg::widen5(colour_ff[4:0]);
   assign rsp_green       = ptr_pkg::widen5(colour_ff[9:5]);
   assign rsp_blue        = ptr_pkg::widen5(colour_ff[14:10]);
   assign rsp_last        = out_last_ff;

endmodule

// ----- rtl/planar_tile_pixel_renderer.sv -----
// ----------------------------------------------------------------------------
// planar_tile_pixel_renderer
// Bitplane character renderer with colour lookup and register port.
// ----------------------------------------------------------------------------
// Write items (video word, colour entry) are written when accepted. A render
// item returns 64 pixel transfers in raster order, last flagged on the 64th.
// The single-port video memory gives one word per cycle and each row's plane
// words are gathered before its eight pixels go out. Affine mode reads the
// map byte, then one video word per pixel ahead of its colour lookup. A new
// item is taken once the previous render has issued its final pixel, while
// that pixel may still sit in the output register. Memory entries never
// written read back undefined.
// ----------------------------------------------------------------------------
module planar_tile_pixel_renderer #(
   parameter int VIDEO_WORDS = ptr_pkg::VIDEO_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [14:0] req_address,
   input  logic [15:0] req_data,
   input  logic [15:0] req_map_entry,
   input  logic [6:0]  req_tile_x,
   input  logic [6:0]  req_tile_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_pixel_col,
   output logic [2:0]  rsp_pixel_row,
   output logic [7:0]  rsp_color_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ptr_pkg::cfg_type    cfg_ff;
   ptr_pkg::cmd_type    cmd;
   ptr_pkg::status_type status;
   logic                csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            ptr_pkg::REG_COLOR_DEPTH: cfg_ff.color_depth    <= pwdata[1:0];
            ptr_pkg::REG_BIG_TILES:   cfg_ff.big_tiles      <= pwdata[0];
            ptr_pkg::REG_HIRES:       cfg_ff.hires          <= pwdata[0];
            ptr_pkg::REG_TILE_BASE:   cfg_ff.tile_data_base <= pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         ptr_pkg::REG_COLOR_DEPTH: prdata = {30'b0, cfg_ff.color_depth};
         ptr_pkg::REG_BIG_TILES:   prdata = {31'b0, cfg_ff.big_tiles};
         ptr_pkg::REG_HIRES:       prdata = {31'b0, cfg_ff.hires};
         ptr_pkg::REG_TILE_BASE:   prdata = {17'b0, cfg_ff.tile_data_base};
         default:                  prdata = '0;
      endcase
   end

   ptr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .cfg_depth  (cfg_ff.color_depth),
      .status     (status),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   ptr_datapath #(
      .VIDEO_WORDS (VIDEO_WORDS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .req_address     (req_address),
      .req_data        (req_data),
      .req_map_entry   (req_map_entry),
      .req_tile_x      (req_tile_x),
      .req_tile_y      (req_tile_y),
      .rsp_ready       (rsp_ready),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_color_index (rsp_color_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- rtl/ptr_checker.sv -----
// ----------------------------------------------------------------------------
// ptr_checker
// Port-level checks of the renderer, bound to the top level.
// ----------------------------------------------------------------------------
module ptr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_pixel_col,
   input logic [2:0]  rsp_pixel_row,
   input logic [7:0]  rsp_color_index,
   input logic [7:0]  rsp_red,
   input logic        rsp_last
);

   // a stalled transfer keeps its pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color_index))
      else $error("stalled pixel changed");

   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ptr_pkg::ACT_RENDER |=> !req_ready)
      else $error("request taken during render");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_pixel_col == 3'd7 && rsp_pixel_row == 3'd7)
      else $error("last flag off the final pixel");

   a_widen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red[2:0] == rsp_red[7:5])
      else $error("red channel not replicated");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid after reset");

endmodule

bind planar_tile_pixel_renderer ptr_checker u_ptr_checker (.*);

// ----- tb/sv/planar_tile_pixel_renderer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// planar_tile_pixel_renderer_tb
// Self-checking bench for the planar tile pixel renderer. A queue of
// requests is built phase by phase under several register settings: 2, 4 and
// 8 bpp, affine, wide and big tiles, and base addresses at both ends. Every
// video word and colour entry a render touches is written first. A clocked
// driver and monitor add random gaps on both channels. Each accepted request
// updates a local model of the block, which queues the 64 pixels due. Each
// pixel transfer is checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
module planar_tile_pixel_renderer_tb;
   import ptr_pkg::*;

   localparam int          VRAM_WORDS      = VIDEO_WORDS_DEF;
   localparam logic [1:0]  ACT_UNUSED      = 2'd3;
   localparam int          NUM_SETTINGS    = 9;
   localparam int          ITEMS_PER_PHASE = 54;
   localparam int          HOLD_OFF        = 150;
   localparam int          WATCHDOG_LIMIT  = 4000;

   typedef struct packed {
      logic [1:0]  action;
      logic [14:0] address;
      logic [15:0] data;
      logic [15:0] map_entry;
      logic [6:0]  tile_x;
      logic [6:0]  tile_y;
   } req_item_t;

   typedef struct packed {
      logic [2:0] col;
      logic [2:0] row;
      logic [7:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } pixel_t;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action      = ACT_VID_WR;
   logic [14:0] req_address     = '0;
   logic [15:0] req_data        = '0;
   logic [15:0] req_map_entry   = '0;
   logic [6:0]  req_tile_x      = '0;
   logic [6:0]  req_tile_y      = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [2:0]  rsp_pixel_col;
   logic [2:0]  rsp_pixel_row;
   logic [7:0]  rsp_color_index;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_last;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [3:0]  paddr           = '0;
   logic [31:0] pwdata          = '0;
   logic [31:0] prdata;
   logic        pready;

   // model state, updated on accepted requests
   logic [15:0] vram_model [VRAM_WORDS];
   logic [14:0] palette_model [COLOUR_ENTRIES];
   cfg_type     cfg_model;
   pixel_t      expected_pixels [$];

   // stimulus-side view of video memory, ahead of the block
   logic [15:0] plan_vram [VRAM_WORDS];
   bit          plan_vram_ok [VRAM_WORDS];
   req_item_t   pending_reqs [$];
   logic [14:0] recent_base  = '0;

   int issued         = 0;
   int useful_items   = 0;
   int accepted       = 0;
   int renders_done   = 0;
   int pixels_checked = 0;
   int mismatches     = 0;
   int req_gap        = 0;
   int rsp_stall      = 0;
   int idle_cycles    = 0;
   int calm_timer     = 0;
   bit calm           = 1'b0;

   planar_tile_pixel_renderer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_address     (req_address),
      .req_data        (req_data),
      .req_map_entry   (req_map_entry),
      .req_tile_x      (req_tile_x),
      .req_tile_y      (req_tile_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_color_index (rsp_color_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // model of the block
   // ------------------------------------------------------------------
   function automatic logic [7:0] stretch5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [14:0] char_base(input logic [15:0] entry,
                                             input logic [6:0] tx,
                                             input logic [6:0] ty);
      logic [9:0] chr;
      logic       wide;
      chr  = entry[9:0];
      wide = cfg_model.big_tiles | cfg_model.hires;
      if (wide && (tx[0] ^ entry[14])) chr = chr + 10'd1;
      if (cfg_model.big_tiles && (ty[0] ^ entry[15])) chr = chr + 10'd16;
      return cfg_model.tile_data_base + 15'(chr) * (15'd8 << cfg_model.color_depth);
   endfunction

   function automatic void push_pixel(input int col, input int row,
                                      input logic [7:0] cidx);
      logic [14:0] c;
      pixel_t      px;
      c              = palette_model[cidx];
      px.col         = 3'(col);
      px.row         = 3'(row);
      px.color_index = cidx;
      px.red         = stretch5(c[4:0]);
      px.green       = stretch5(c[9:5]);
      px.blue        = stretch5(c[14:10]);
      px.last        = (row == 7) && (col == 7);
      expected_pixels.push_back(px);
   endfunction

   function automatic void apply_request(input req_item_t it);
      logic [14:0] base;
      logic [7:0]  chr8;
      logic [7:0]  cidx;
      logic [7:0]  offset;
      logic [15:0] w;
      int          planes;
      int          src_row;
      int          bitp;
      case (it.action)
         ACT_VID_WR: vram_model[it.address] = it.data;
         ACT_COL_WR: palette_model[it.address[7:0]] = it.data[14:0];
         ACT_RENDER: begin
            renders_done++;
            if (cfg_model.color_depth == DEPTH_AFFINE) begin
               chr8 = vram_model[{1'b0, it.tile_y, it.tile_x}][7:0];
               for (int row = 0; row < 8; row++)
                  for (int col = 0; col < 8; col++) begin
                     w = vram_model[{1'b0, chr8, 3'(row), 3'(col)}];
                     push_pixel(col, row, w[15:8]);
                  end
            end else begin
               planes = 1 << cfg_model.color_depth;
               offset = 8'(int'(it.map_entry[12:10]) << (2 << cfg_model.color_depth));
               base   = char_base(it.map_entry, it.tile_x, it.tile_y);
               for (int row = 0; row < 8; row++) begin
                  src_row = it.map_entry[15] ? 7 - row : row;
                  for (int col = 0; col < 8; col++) begin
                     bitp = it.map_entry[14] ? col : 7 - col;
                     cidx = '0;
                     for (int p = 0; p < planes; p++) begin
                        w             = vram_model[15'(base + src_row + 8 * p)];
                        cidx[2*p]     = w[bitp];
                        cidx[2*p + 1] = w[bitp + 8];
                     end
                     push_pixel(col, row, cidx + offset);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_item(input req_item_t it);
      pending_reqs.push_back(it);
      issued++;
      if (it.action != ACT_UNUSED) useful_items++;
      if (it.action == ACT_VID_WR) begin
         plan_vram[it.address]    = it.data;
         plan_vram_ok[it.address] = 1'b1;
      end
   endtask

   task automatic queue_video_write(input logic [14:0] addr, input logic [15:0] value);
      queue_item('{ACT_VID_WR, addr, value, 16'($urandom), 7'($urandom), 7'($urandom)});
   endtask

   task automatic need_word(input logic [14:0] addr);
      if (!plan_vram_ok[addr]) queue_video_write(addr, 16'($urandom));
   endtask

   // writes whatever the render will read, then the render itself
   task automatic queue_render(input logic [15:0] entry, input logic [6:0] tx,
                               input logic [6:0] ty);
      logic [14:0] base;
      logic [14:0] map_addr;
      logic [7:0]  chr8;
      if (cfg_model.color_depth == DEPTH_AFFINE) begin
         map_addr = {1'b0, ty, tx};
         if (!plan_vram_ok[map_addr])
            queue_video_write(map_addr, {8'($urandom), 8'($urandom_range(0, 3))});
         chr8        = plan_vram[map_addr][7:0];
         recent_base = {1'b0, chr8, 6'd0};
         for (int n = 0; n < 64; n++) need_word({1'b0, chr8, 6'(n)});
      end else begin
         base        = char_base(entry, tx, ty);
         recent_base = base;
         for (int n = 0; n < (8 << cfg_model.color_depth); n++) need_word(15'(base + n));
      end
      queue_item('{ACT_RENDER, 15'($urandom), 16'($urandom), entry, tx, ty});
   endtask

   function automatic logic [15:0] random_entry();
      logic [15:0] e;
      e = 16'($urandom);
      case ($urandom_range(0, 9))
         0: e[9:0] = 10'h000;
         1: e[9:0] = 10'h001;
         2: e[9:0] = 10'h010;
         3: e[9:0] = 10'h3ff;
         4: e[9:0] = 10'h3ef;
         5: e[9:0] = 10'h3f0;
         default: ;
      endcase
      return e;
   endfunction

   function automatic logic [6:0] random_tile();
      return $urandom_range(0, 1) ? 7'($urandom_range(0, 3)) : 7'($urandom);
   endfunction

   function automatic cfg_type phase_setting(input int ph);
      cfg_type s;
      s.tile_data_base = 15'($urandom);
      case (ph)
         0: begin
            s.color_depth = DEPTH_2BPP; s.big_tiles = 1'b0; s.hires = 1'b0;
            s.tile_data_base = 15'h0000;
         end
         1: begin
            s.color_depth = DEPTH_4BPP; s.big_tiles = 1'b1; s.hires = 1'b0;
            s.tile_data_base = 15'h7fff;
         end
         2: begin
            s.color_depth = DEPTH_8BPP; s.big_tiles = 1'b0; s.hires = 1'b1;
         end
         3: begin
            s.color_depth = DEPTH_AFFINE; s.big_tiles = 1'b0; s.hires = 1'b0;
            s.tile_data_base = 15'h0000;
         end
         4: begin
            s.color_depth = DEPTH_2BPP; s.big_tiles = 1'b1; s.hires = 1'b1;
            s.tile_data_base = 15'h7ff8;
         end
         5: begin
            s.color_depth = DEPTH_8BPP; s.big_tiles = 1'b1; s.hires = 1'b1;
            s.tile_data_base = 15'h7fff;
         end
         6: begin
            s.color_depth = DEPTH_4BPP; s.big_tiles = 1'b0; s.hires = 1'b1;
         end
         7: begin
            s.color_depth = DEPTH_AFFINE; s.big_tiles = 1'b1; s.hires = 1'b1;
            s.tile_data_base = 15'h7fff;
         end
         default: begin
            s.color_depth = DEPTH_2BPP; s.big_tiles = 1'b1; s.hires = 1'b0;
         end
      endcase
      return s;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [14:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_COLOR_DEPTH: cfg_model.color_depth    = value[1:0];
         REG_BIG_TILES:   cfg_model.big_tiles      = value[0];
         REG_HIRES:       cfg_model.hires          = value[0];
         REG_TILE_BASE:   cfg_model.tile_data_base = value;
         default: ;
      endcase
   endtask

   task automatic drain_and_hold();
      while (accepted != issued || expected_pixels.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      cfg_type   s;
      int        phase_start;
      int        r;
      cfg_model = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
         drain_and_hold();
         s = phase_setting(ph);
         csr_write(REG_COLOR_DEPTH, 15'(s.color_depth));
         csr_write(REG_BIG_TILES, 15'(s.big_tiles));
         csr_write(REG_HIRES, 15'(s.hires));
         csr_write(REG_TILE_BASE, s.tile_data_base);

         if (ph == 0) begin
            // colour table fill, extremes at both ends
            for (int i = 0; i < COLOUR_ENTRIES; i++)
               queue_item('{ACT_COL_WR, 15'(i),
                            (i == 0) ? 16'h0000 : (i == 255) ? 16'hffff : 16'($urandom),
                            16'($urandom), 7'($urandom), 7'($urandom)});
            queue_item('{ACT_COL_WR, 15'h7fff, 16'hffff, 16'h0000, 7'h00, 7'h00});
            queue_video_write(15'h0000, 16'hffff);
            queue_video_write(15'h7fff, 16'h0000);
            queue_item('{ACT_UNUSED, 15'h7fff, 16'hffff, 16'hffff, 7'h7f, 7'h7f});
            queue_item('{ACT_UNUSED, 15'h0000, 16'h0000, 16'h0000, 7'h00, 7'h00});
         end

         // corners, mirrored sub-tiles and character number wrap
         queue_render(16'h0000, 7'd0, 7'd0);
         queue_render(16'hffff, 7'd127, 7'd127);
         queue_render(16'h03ff, 7'd1, 7'd0);
         queue_render(16'h83f8, 7'd0, 7'd0);

         phase_start = useful_items;
         while (useful_items - phase_start < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 60)
               queue_render(random_entry(), random_tile(), random_tile());
            else if (r < 78)
               queue_video_write($urandom_range(0, 1) ? 15'(recent_base + $urandom_range(0, 63))
                                                      : 15'($urandom),
                                 16'($urandom));
            else if (r < 93)
               queue_item('{ACT_COL_WR, 15'($urandom), 16'($urandom),
                            16'($urandom), 7'($urandom), 7'($urandom)});
            else
               queue_item('{ACT_UNUSED, 15'($urandom), 16'($urandom),
                            16'($urandom), 7'($urandom), 7'($urandom)});
         end
      end

      drain_and_hold();
      $display("%0d requests accepted, %0d renders, %0d pixel transfers checked",
               accepted, renders_done, pixels_checked);
      $display("register settings covered: %0d (2/4/8 bpp, affine, wide and big tiles)",
               NUM_SETTINGS);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // idle pattern: stretches without any gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (calm_timer == 0) begin
         calm       <= ($urandom_range(0, 3) == 0);
         calm_timer <= $urandom_range(100, 600);
      end else begin
         calm_timer <= calm_timer - 1;
      end
   end

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      req_item_t nxt;
      logic      holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            apply_request('{req_action, req_address, req_data, req_map_entry,
                            req_tile_x, req_tile_y});
            accepted++;
         end
         if (!holding) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_action    <= nxt.action;
               req_address   <= nxt.address;
               req_data      <= nxt.data;
               req_map_entry <= nxt.map_entry;
               req_tile_x    <= nxt.tile_x;
               req_tile_y    <= nxt.tile_y;
               req_valid     <= 1'b1;
               req_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // pixel monitor
   // ------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch_pixels
      pixel_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
               $error("pixel transfer with nothing expected");
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_col", 8'(want.col), 8'(rsp_pixel_col));
               check_field("pixel_row", 8'(want.row), 8'(rsp_pixel_row));
               check_field("color_index", want.color_index, rsp_color_index);
               check_field("red", want.red, rsp_red);
               check_field("green", want.green, rsp_green);
               check_field("blue", want.blue, rsp_blue);
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: no transfer of any kind for too long
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
rtl/ptr_pkg.sv
rtl/ptr_ctrl.sv
rtl/ptr_datapath.sv
rtl/planar_tile_pixel_renderer.sv
rtl/ptr_checker.sv
tb/sv/planar_tile_pixel_renderer_tb.sv
